[sv/kti_pkg.sv]
// package: shared types and constants of the keyframe track interpolator
package kti_pkg;

   localparam int MAX_KEYS = 64;
   localparam int IDX_W    = $clog2(MAX_KEYS);
   localparam int CNT_W    = $clog2(MAX_KEYS + 1);

   localparam logic [1:0] FUNC_ADD     = 2'd0;
   localparam logic [1:0] FUNC_SEEK    = 2'd1;
   localparam logic [1:0] FUNC_ADVANCE = 2'd2;

   localparam logic [1:0] STATUS_INTERP = 2'd0;
   localparam logic [1:0] STATUS_HOLD   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [1:0] STATUS_FULL   = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [31:0]        key_time;
      logic signed [31:0] key_value;
      logic [15:0]        time_delta;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } rsp_type;

endpackage

[sv/kti_ram.sv]
// generic single-write, single-read ram with registered read data
module kti_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/keyframe_track_interpolator.sv]
// top level: keyframe table, time position and interpolation sequencer
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | kti_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | kti_pkg::rsp_type
//
// one request at a time; the table sits in one ram with registered read data.
// add: each key later than the new one is shifted up by one, then position search.
// position search: reads and compares one key at a time. interpolation: a
// multiply, then the bit-per-cycle 64-bit restoring divider, then a fix-up.
// reset: synchronous, clears count, position and sequencer; no ram clearing.
// a finished response waits in the output register; the next request is
// accepted meanwhile, and its response waits while rsp_stall is high.
module keyframe_track_interpolator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kti_pkg::rsp_type rsp_data
);
   import kti_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_INS_RD  = 13'b0000000000010,
      ST_INS_WR  = 13'b0000000000100,
      ST_INS_PUT = 13'b0000000001000,
      ST_FWD_RD  = 13'b0000000010000,
      ST_FWD_CMP = 13'b0000000100000,
      ST_INT_RD0 = 13'b0000001000000,
      ST_INT_RD1 = 13'b0000010000000,
      ST_INT_CHK = 13'b0000100000000,
      ST_INT_MUL = 13'b0001000000000,
      ST_DIV     = 13'b0010000000000,
      ST_FIX     = 13'b0100000000000,
      ST_FIN     = 13'b1000000000000
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   prev_ff, prev_in;
   logic [31:0]        cur_ff, cur_in;
   logic               rej_ff, rej_in;
   logic               rsp_valid_ff, rsp_valid_in;
   // working registers
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [31:0]        new_time_ff, new_time_in;
   logic signed [31:0] new_value_ff, new_value_in;
   logic [31:0]        t0_ff, t0_in;
   logic signed [31:0] v0_ff, v0_in;
   logic               neg_ff, neg_in;
   logic [31:0]        mag_ff, mag_in;
   logic [31:0]        num_ff, num_in;
   logic [31:0]        dur_ff, dur_in;
   logic [63:0]        dvd_ff, dvd_in;
   logic [32:0]        rem_ff, rem_in;
   logic [5:0]         dcnt_ff, dcnt_in;
   // result being built, kept apart from the response still waiting
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;

   // ram port
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [63:0]        wr_data, rd_data;
   logic [31:0]        rd_time;
   logic signed [31:0] rd_value;

   logic [CNT_W-1:0]   prev_next;
   logic [32:0]        sum;
   logic signed [32:0] diff;
   logic [32:0]        rem_sh;
   logic signed [33:0] base;

   kti_ram #(.WIDTH(64), .DEPTH(MAX_KEYS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_time   = rd_data[63:32];
   assign rd_value  = rd_data[31:0];
   assign prev_next = {{(CNT_W-IDX_W){1'b0}}, prev_ff} + 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      new_time_in  = new_time_ff;
      new_value_in = new_value_ff;
      t0_in        = t0_ff;
      v0_in        = v0_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      num_in       = num_ff;
      dur_in       = dur_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IDX_W-1:0];
      wr_data      = rd_data;
      rd_addr      = prev_ff;
      sum          = {1'b0, cur_ff} + {17'd0, req_data.time_delta};
      diff         = 33'(rd_value) - 33'(v0_ff);
      rem_sh       = {rem_ff[31:0], dvd_ff[63]};
      base         = neg_ff ? (34'(v0_ff) - 34'(dvd_ff[31:0]))
                            : (34'(v0_ff) + 34'(dvd_ff[31:0]));

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rej_in = 1'b0;
               case (req_data.func)
                  FUNC_ADD: begin
                     if (count_ff == CNT_W'(MAX_KEYS)) begin
                        rej_in   = 1'b1;
                        state_in = ST_INT_RD0;
                     end else begin
                        new_time_in  = req_data.key_time;
                        new_value_in = req_data.key_value;
                        idx_in       = count_ff;
                        state_in     = (count_ff == '0) ? ST_INS_PUT : ST_INS_RD;
                     end
                  end
                  FUNC_SEEK: begin
                     cur_in   = req_data.key_time;
                     prev_in  = '0;
                     state_in = ST_FWD_RD;
                  end
                  FUNC_ADVANCE: begin
                     cur_in   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                     state_in = ST_FWD_RD;
                  end
                  default: begin
                     state_in = ST_INT_RD0;
                  end
               endcase
            end
         end
         // shift keys later than the new one up by one, from the top down
         ST_INS_RD: begin
            rd_addr  = IDX_W'(idx_ff - 1'b1);
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            if (rd_time > new_time_ff) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               idx_in   = idx_ff - 1'b1;
               state_in = (idx_ff == CNT_W'(1)) ? ST_INS_PUT : ST_INS_RD;
            end else begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_data  = {new_time_ff, new_value_ff};
            count_in = count_ff + 1'b1;
            cur_in   = '0;
            prev_in  = '0;
            state_in = ST_FWD_RD;
         end
         // walk forward to the last key not later than the current time
         ST_FWD_RD: begin
            rd_addr = prev_next[IDX_W-1:0];
            if (prev_next < count_ff) begin
               state_in = ST_FWD_CMP;
            end else begin
               state_in = ST_INT_RD0;
            end
         end
         ST_FWD_CMP: begin
            if (cur_ff >= rd_time) begin
               prev_in  = prev_next[IDX_W-1:0];
               state_in = ST_FWD_RD;
            end else begin
               state_in = ST_INT_RD0;
            end
         end
         ST_INT_RD0: begin
            rd_addr = prev_ff;
            if (count_ff == '0) begin
               res_in.value  = '0;
               res_in.status = STATUS_EMPTY;
               state_in      = ST_FIN;
            end else begin
               state_in = ST_INT_RD1;
            end
         end
         ST_INT_RD1: begin
            rd_addr       = prev_next[IDX_W-1:0];
            t0_in         = rd_time;
            v0_in         = rd_value;
            res_in.value  = rd_value;
            if (prev_next >= count_ff) begin
               res_in.status = STATUS_HOLD;
               state_in      = ST_FIN;
            end else begin
               res_in.status = STATUS_INTERP;
               state_in      = ST_INT_CHK;
            end
         end
         ST_INT_CHK: begin
            // before the first key or zero duration: value stays v0
            if (cur_ff < t0_ff || rd_time == t0_ff) begin
               state_in = ST_FIN;
            end else begin
               neg_in   = diff[32];
               mag_in   = diff[32] ? 32'(-diff) : diff[31:0];
               num_in   = cur_ff - t0_ff;
               dur_in   = rd_time - t0_ff;
               state_in = ST_INT_MUL;
            end
         end
         ST_INT_MUL: begin
            dvd_in   = 64'(mag_ff) * 64'(num_ff);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         // restoring divide, one quotient bit per cycle
         ST_DIV: begin
            if (rem_sh >= {1'b0, dur_ff}) begin
               rem_in = rem_sh - {1'b0, dur_ff};
               dvd_in = {dvd_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               dvd_in = {dvd_ff[62:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 6'd63) begin
               state_in = ST_FIX;
            end
         end
         // truncate toward zero when the quotient is inexact
         ST_FIX: begin
            if (rem_ff != '0 && !neg_ff && base < 0) begin
               base = base + 34'sd1;
            end else if (rem_ff != '0 && neg_ff && base > 0) begin
               base = base - 34'sd1;
            end
            res_in.value = base[31:0];
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = res_ff;
               if (rej_ff) begin
                  rsp_in.status = STATUS_FULL;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         prev_ff      <= '0;
         cur_ff       <= '0;
         rej_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         cur_ff       <= cur_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      new_time_ff  <= new_time_in;
      new_value_ff <= new_value_in;
      t0_ff        <= t0_in;
      v0_ff        <= v0_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      num_ff       <= num_in;
      dur_ff       <= dur_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      dcnt_ff      <= dcnt_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

endmodule

[bench/keyframe_track_interpolator_tb.sv]
// testbench: keyframe track interpolator, directed table, fill to the top, then random requests vs predictor
`timescale 1ns / 100ps

module keyframe_track_interpolator_tb;
   import kti_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   keyframe_track_interpolator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: own copy of the track
   logic [31:0]        trk_time [MAX_KEYS];
   logic signed [31:0] trk_val  [MAX_KEYS];
   int unsigned        trk_count;
   int unsigned        trk_prev;
   logic [31:0]        trk_now;

   rsp_type expected_rsps[$];
   int      fail_count = 0;
   longint  cycle_count = 0;

   // directed table: check_fixed marks rows whose answer is typed in
   typedef struct {
      req_type req;
      bit      check_fixed;
      rsp_type rsp;
   } vector_row_type;

   vector_row_type vectors[$];

   // walk prev_index forward to last key not later than now
   function automatic void track_walk();
      while (trk_prev + 1 < trk_count && trk_now >= trk_time[trk_prev + 1])
         trk_prev++;
   endfunction

   function automatic void track_advance(logic [32:0] delta);
      logic [32:0] sum;
      sum = {1'b0, trk_now} + delta;
      trk_now = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      track_walk();
   endfunction

   function automatic rsp_type track_value();
      rsp_type r;
      longint v0, v1, d, q, base;
      logic [63:0] mag, num, dur, prod, rem;
      r = '0;
      if (trk_count == 0 || trk_prev >= trk_count) begin
         r.status = STATUS_EMPTY;
         return r;
      end
      v0 = trk_val[trk_prev];
      if (trk_prev + 1 >= trk_count) begin
         r.value = v0[31:0];
         r.status = STATUS_HOLD;
         return r;
      end
      r.status = STATUS_INTERP;
      r.value = v0[31:0];
      // before the first key, or zero duration: value is v0
      if (trk_now < trk_time[trk_prev]) return r;
      dur = {32'd0, trk_time[trk_prev + 1]} - {32'd0, trk_time[trk_prev]};
      if (dur == 0) return r;
      num = {32'd0, trk_now} - {32'd0, trk_time[trk_prev]};
      v1 = trk_val[trk_prev + 1];
      d = v1 - v0;
      mag = (d < 0) ? -d : d;
      prod = mag * num;
      q = prod / dur;
      rem = prod % dur;
      if (d >= 0) begin
         base = v0 + q;
         if (rem != 0 && base < 0) base += 1;
      end else begin
         base = v0 - q;
         if (rem != 0 && base > 0) base -= 1;
      end
      r.value = base[31:0];
      return r;
   endfunction

   function automatic rsp_type track_apply(req_type rq);
      rsp_type r;
      int unsigned pos;
      bit rejected;
      rejected = 1'b0;
      case (rq.func)
         FUNC_ADD: begin
            if (trk_count >= MAX_KEYS) begin
               rejected = 1'b1;
            end else begin
               pos = 0;
               while (pos < trk_count && trk_time[pos] <= rq.key_time) pos++;
               for (int i = trk_count; i > pos; i--) begin
                  trk_time[i] = trk_time[i - 1];
                  trk_val[i]  = trk_val[i - 1];
               end
               trk_time[pos] = rq.key_time;
               trk_val[pos]  = rq.key_value;
               trk_count++;
               trk_now = '0;
               trk_prev = 0;
               track_walk();
            end
         end
         FUNC_SEEK: begin
            trk_now = '0;
            trk_prev = 0;
            track_advance({1'b0, rq.key_time});
         end
         FUNC_ADVANCE: track_advance({17'd0, rq.time_delta});
         default: ;
      endcase
      r = track_value();
      if (rejected) r.status = STATUS_FULL;
      return r;
   endfunction

   function automatic req_type mk_req(logic [1:0] f, logic [31:0] t,
                                      logic [31:0] v, logic [15:0] dt);
      req_type rq;
      rq.func = f;
      rq.key_time = t;
      rq.key_value = v;
      rq.time_delta = dt;
      return rq;
   endfunction

   function automatic void add_row(req_type rq, bit fixed, logic signed [31:0] v,
                                   logic [1:0] s);
      vector_row_type row;
      row.req = rq;
      row.check_fixed = fixed;
      row.rsp.value = v;
      row.rsp.status = s;
      vectors = {vectors, row};
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   // drive one request and record what the track should answer
   task automatic send_request(req_type rq, bit fixed, rsp_type fixed_rsp);
      rsp_type pred;
      int gap;
      pred = track_apply(rq);
      if (fixed && pred !== fixed_rsp)
         $error("table row disagrees with predictor: exp %h pred %h", fixed_rsp, pred);
      expected_rsps = {expected_rsps, (fixed ? fixed_rsp : pred)};
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data  <= mk_req(2'($urandom), $urandom, $urandom, 16'($urandom));
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_time(int spread);
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 3);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         2: return $urandom;
         default: return $urandom_range(0, spread);
      endcase
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // response side: random stall, compare with oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected: %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.value !== want.value) begin
                  $error("value: expected %h actual %h", want.value, rsp_data.value);
                  fail_count <= fail_count + 1;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_data.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // mostly short random stalls, with some free-running stretches
         if ((cycle_count / 4000) % 4 == 3) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(0, 99) < 30) ||
                           ($urandom_range(0, 999) < 3);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      trk_count = 0;
      trk_prev = 0;
      trk_now = '0;

      // empty table, unused func, extremes, ties, before-first, saturation
      add_row(mk_req(FUNC_SEEK, 32'd5, 0, 0), 1, 0, STATUS_EMPTY);
      add_row(mk_req(FUNC_ADVANCE, 0, 0, 16'hFFFF), 1, 0, STATUS_EMPTY);
      add_row(mk_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF), 1, 0, STATUS_EMPTY);
      add_row(mk_req(FUNC_ADD, 32'd100, 32'h7FFF_FFFF, 0), 1, 32'h7FFF_FFFF, STATUS_HOLD);
      add_row(mk_req(FUNC_ADD, 32'd200, 32'h8000_0000, 0), 1, 32'h7FFF_FFFF, STATUS_INTERP);
      add_row(mk_req(FUNC_SEEK, 32'd150, 0, 0), 0, 0, 0);
      add_row(mk_req(FUNC_ADVANCE, 0, 0, 16'd49), 0, 0, 0);
      add_row(mk_req(FUNC_ADVANCE, 0, 0, 16'd1), 1, 32'h8000_0000, STATUS_HOLD);
      add_row(mk_req(FUNC_ADD, 32'd200, 32'h0001_0000, 0), 0, 0, 0);
      add_row(mk_req(FUNC_SEEK, 32'd200, 0, 0), 1, 32'h0001_0000, STATUS_HOLD);
      add_row(mk_req(FUNC_ADD, 32'd0, 32'h0000_0000, 0), 0, 0, 0);
      add_row(mk_req(FUNC_ADD, 32'd0, 32'hFFFF_0000, 0), 0, 0, 0);
      add_row(mk_req(FUNC_SEEK, 32'd7, 0, 0), 0, 0, 0);
      add_row(mk_req(FUNC_ADD, 32'hFFFF_FFFF, 32'h1234_5678, 0), 0, 0, 0);
      add_row(mk_req(FUNC_SEEK, 32'hFFFF_FFF0, 0, 0), 0, 0, 0);
      add_row(mk_req(FUNC_ADVANCE, 0, 0, 16'hFFFF), 1, 32'h1234_5678, STATUS_HOLD);
      add_row(mk_req(FUNC_SEEK, 32'd123_456, 0, 16'h5555), 0, 0, 0);
      add_row(mk_req(2'd3, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA), 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) send_request(vectors[i].req, vectors[i].check_fixed,
                                        vectors[i].rsp);

      // fill the table to the top, then one rejected add
      while (trk_count < MAX_KEYS)
         send_request(mk_req(FUNC_ADD, rand_time(5000), rand_value(), 0), 0, none);
      send_request(mk_req(FUNC_ADD, 32'd1, 32'd1, 0), 0, none);

      // random: mostly seek/advance walks over a full table, adds rarely
      for (int n = 0; n < 2000; n++) begin
         int p;
         p = $urandom_range(0, 99);
         if (p < 8)
            send_request(mk_req(FUNC_ADD, rand_time(5000), rand_value(),
                                16'($urandom)), 0, none);
         else if (p < 30)
            send_request(mk_req(FUNC_SEEK, rand_time(5000), $urandom, 16'($urandom)),
                         0, none);
         else if (p < 95)
            send_request(mk_req(FUNC_ADVANCE, $urandom, $urandom,
                                16'(($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(0, 200))),
                         0, none);
         else
            send_request(mk_req(2'd3, $urandom, $urandom, 16'($urandom)), 0, none);
      end
      req_valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
